// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted (active low).
`define PHCC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also runs during reset.
`define PHCC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/phcc_pkg.sv
// ----------------------------------------------------------------------------
// phcc_pkg
// Shared types and constants of the path history crossing counter.
// ----------------------------------------------------------------------------
package phcc_pkg;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam int WEIGHT_W      = 16;
    localparam int STEP_W        = 32;
    localparam int LIMIT_W       = 10;
    localparam int SKIP_W        = 9;
    localparam int HIT_COUNT_W   = 9;
    localparam int PENALTY_W     = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CROSS_ENABLE  = 3'd0,
        CFG_CROSS_WEIGHT  = 3'd1,
        CFG_MIN_STEP_SQ   = 3'd2,
        CFG_HISTORY_LIMIT = 3'd3,
        CFG_SKIP_RECENT   = 3'd4
    } phcc_cfg_idx_t;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    localparam logic                RST_CROSS_ENABLE  = 1'b1;
    localparam logic [WEIGHT_W-1:0] RST_CROSS_WEIGHT  = 16'd1280;
    localparam logic [STEP_W-1:0]   RST_MIN_STEP_SQ   = 32'd1024;
    localparam logic [LIMIT_W-1:0]  RST_HISTORY_LIMIT = 10'd300;
    localparam logic [SKIP_W-1:0]   RST_SKIP_RECENT   = 9'd5;

    // Sign of a cross product: both bits low means zero.
    typedef struct packed {
        logic pos;
        logic neg;
    } phcc_sign_t;

endpackage

// File: rtl/phcc_ram.sv
// ----------------------------------------------------------------------------
// phcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module phcc_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/path_history_crossing_counter.sv
// ----------------------------------------------------------------------------
// path_history_crossing_counter
// Ring of past 2D positions; counts proper crossings of a query segment with
// the stored polyline and scales the count by a Q8.8 weight.
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  input     | s_valid / s_ready  | s_func, s_pos_x/y/z, s_target_x/y
//  result    | m_valid / m_ready  | m_hit_count, m_penalty (queries only)
//  config    | cfg_wr_en          | cfg_index, cfg_wdata (write only, no wait)
//
//  Sequence: an append keeps the block busy after acceptance through the
//  spacing check and the store (just the store when the ring is empty; a
//  point too close is dropped after the check). A query walks (stored -
//  skip_recent) points through the shared cross-product unit, with one
//  orientation for the first point and three for each one after it, then
//  scales the count; a disabled or short query goes straight to scaling.
//  Reset clears the ring bookkeeping and loads register defaults; the ring
//  memory itself is not cleared. A result waiting on m_ready does not block
//  the next transaction; only a second result stalls behind it.
//
module path_history_crossing_counter
    import phcc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 512,
    parameter int COORD_WIDTH   = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_wdata,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic signed [COORD_WIDTH-1:0]  s_pos_x,
    input  logic signed [COORD_WIDTH-1:0]  s_pos_y,
    input  logic signed [COORD_WIDTH-1:0]  s_pos_z,
    input  logic signed [COORD_WIDTH-1:0]  s_target_x,
    input  logic signed [COORD_WIDTH-1:0]  s_target_y,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [HIT_COUNT_W-1:0]         m_hit_count,
    output logic [PENALTY_W-1:0]           m_penalty
);

    // Ring addressing and counts
    localparam int IW    = $clog2(HISTORY_DEPTH);
    localparam int CNTW  = $clog2(HISTORY_DEPTH + 1);
    localparam int LW    = (CNTW > LIMIT_W) ? CNTW : LIMIT_W;
    localparam int SW    = IW + 2;
    // Arithmetic widths: coordinate differences, products, cross products
    localparam int DW    = COORD_WIDTH + 1;
    localparam int PW    = 2 * DW;
    localparam int XW    = PW + 1;
    localparam int SQW   = 2 * COORD_WIDTH + 2;
    localparam int CMPW  = (SQW > STEP_W) ? SQW : STEP_W;
    // Output scaling widths
    localparam int CCW   = (CNTW > HIT_COUNT_W) ? CNTW : HIT_COUNT_W;
    localparam int PENW0 = CNTW + WEIGHT_W;
    localparam int PENW  = (PENW0 > PENALTY_W) ? PENW0 : PENALTY_W;

    localparam logic [IW-1:0]   LAST_ADDR = IW'(HISTORY_DEPTH - 1);
    localparam logic [SW-1:0]   DEPTH_SW  = SW'(HISTORY_DEPTH);
    localparam logic [LW:0]     DEPTH_LW  = (LW + 1)'(HISTORY_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_X,     // issue dx^2
        ST_A_Y,     // take dx^2, issue dy^2
        ST_A_Z,     // add dy^2, issue dz^2
        ST_A_C,     // add dz^2, compare against min spacing
        ST_A_WR,    // store point, update ring
        ST_Q_LD,    // latch point from ring
        ST_Q_XA,    // issue orientation of point vs query line
        ST_Q_X3,    // take it, issue orientation of query start vs segment
        ST_Q_X4,    // take it, issue orientation of query end vs segment
        ST_Q_EV,    // evaluate crossing, advance
        ST_Q_OUT    // scale and hand to output register
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic                   cross_enable_reg;
    logic [WEIGHT_W-1:0]    cross_weight_reg;
    logic [STEP_W-1:0]      min_step_sq_reg;
    logic [LIMIT_W-1:0]     history_limit_reg;
    logic [SKIP_W-1:0]      skip_recent_reg;

    // Ring bookkeeping and last stored point
    logic [IW-1:0]          oldest_reg, oldest_next;
    logic [CNTW-1:0]        count_reg, count_next;
    logic signed [COORD_WIDTH-1:0] lp_x_reg, lp_x_next;
    logic signed [COORD_WIDTH-1:0] lp_y_reg, lp_y_next;
    logic signed [COORD_WIDTH-1:0] lp_z_reg, lp_z_next;

    // Captured transaction
    logic signed [COORD_WIDTH-1:0] ax_reg, ax_next;
    logic signed [COORD_WIDTH-1:0] ay_reg, ay_next;
    logic signed [COORD_WIDTH-1:0] az_reg, az_next;
    logic signed [COORD_WIDTH-1:0] bx_reg, bx_next;
    logic signed [COORD_WIDTH-1:0] by_reg, by_next;

    // Walk state
    logic [IW-1:0]          rd_addr_reg, rd_addr_next;
    logic [CNTW-1:0]        pts_left_reg, pts_left_next;
    logic                   first_reg, first_next;
    logic [CNTW-1:0]        n_reg, n_next;
    logic signed [COORD_WIDTH-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_WIDTH-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_WIDTH-1:0] prev_x_reg, prev_x_next;
    logic signed [COORD_WIDTH-1:0] prev_y_reg, prev_y_next;
    phcc_sign_t             sa_prev_reg, sa_prev_next;
    phcc_sign_t             sa_cur_reg, sa_cur_next;
    phcc_sign_t             s3_reg, s3_next;
    logic [SQW-1:0]         acc_reg, acc_next;

    // Shared cross-product unit
    logic signed [DW-1:0]   op_ux, op_uy, op_vx, op_vy;
    logic signed [PW-1:0]   prod1_reg, prod1_next;
    logic signed [PW-1:0]   prod2_reg, prod2_next;
    logic signed [XW-1:0]   cross_val;
    phcc_sign_t             cross_sign;
    logic [SQW-1:0]         sq_val;
    logic [SQW-1:0]         sq_total;

    // Output register
    logic                     m_valid_reg, m_valid_next;
    logic [HIT_COUNT_W-1:0]   m_hit_count_reg, m_hit_count_next;
    logic [PENALTY_W-1:0]     m_penalty_reg, m_penalty_next;

    // Ring helpers
    logic [CNTW-1:0]        eff_limit;
    logic [LW:0]            limit_ext;
    logic [SW-1:0]          slot_sum;
    logic [IW-1:0]          wr_slot;
    logic [CNTW:0]          grown_count;
    logic [CNTW:0]          drop_cnt;
    logic [SW-1:0]          drop_sum;
    logic [IW-1:0]          oldest_dropped;
    logic                   query_runs;
    logic [CNTW-1:0]        walk_points;
    logic [CCW-1:0]         n_ext;
    logic [PENW-1:0]        pen_full;
    logic                   advance;
    logic                   m_load;

    logic [2*COORD_WIDTH-1:0] ram_rdata;
    logic                     ram_we;

    function automatic logic signed [DW-1:0] sdiff(
        input logic signed [COORD_WIDTH-1:0] p,
        input logic signed [COORD_WIDTH-1:0] q
    );
        logic signed [DW-1:0] pe, qe;
        pe = {p[COORD_WIDTH-1], p};
        qe = {q[COORD_WIDTH-1], q};
        return pe - qe;
    endfunction

    function automatic phcc_sign_t opposite(input phcc_sign_t s, input phcc_sign_t t);
        phcc_sign_t r;
        r.pos = (s.pos && t.neg) || (s.neg && t.pos);
        r.neg = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Ring memory: one (x,y) pair per slot
    // ------------------------------------------------------------------------
    assign ram_we = (state_reg == ST_A_WR);

    phcc_ram #(
        .DATA_W (2 * COORD_WIDTH),
        .DEPTH  (HISTORY_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_slot),
        .wr_data ({ax_reg, ay_reg}),
        .rd_addr (rd_addr_next),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Ring arithmetic
    // ------------------------------------------------------------------------
    // Clamp the point limit into [1, depth].
    assign limit_ext = (LW + 1)'(history_limit_reg);
    always_comb begin
        if (history_limit_reg == '0) begin
            eff_limit = CNTW'(1);
        end else if (limit_ext > DEPTH_LW) begin
            eff_limit = CNTW'(HISTORY_DEPTH);
        end else begin
            eff_limit = CNTW'(limit_ext);
        end
    end

    // Next free slot: oldest + count, wrapped once.
    assign slot_sum = SW'(oldest_reg) + SW'(count_reg);
    assign wr_slot  = (slot_sum >= DEPTH_SW) ? IW'(slot_sum - DEPTH_SW) : IW'(slot_sum);

    // Drop the oldest points that exceed the limit after a store.
    assign grown_count    = (CNTW + 1)'(count_reg) + (CNTW + 1)'(1);
    assign drop_cnt       = grown_count - (CNTW + 1)'(eff_limit);
    assign drop_sum       = SW'(oldest_reg) + SW'(drop_cnt);
    assign oldest_dropped = (drop_sum >= DEPTH_SW) ? IW'(drop_sum - DEPTH_SW)
                                                   : IW'(drop_sum);

    // Walk only when at least two segments survive the skip.
    assign query_runs  = cross_enable_reg &&
                         ((LW + 2)'(count_reg) >= ((LW + 2)'(skip_recent_reg) + (LW + 2)'(3)));
    assign walk_points = count_reg - CNTW'(skip_recent_reg);

    // ------------------------------------------------------------------------
    // Shared cross-product unit: u x v = ux*vy - uy*vx.
    // Products are registered; sign and square follow from them in the next cycle.
    // ------------------------------------------------------------------------
    always_comb begin
        op_ux = '0;
        op_uy = '0;
        op_vx = '0;
        op_vy = '0;
        case (state_reg)
            ST_A_X: begin
                op_ux = sdiff(ax_reg, lp_x_reg);
                op_vy = op_ux;
            end
            ST_A_Y: begin
                op_ux = sdiff(ay_reg, lp_y_reg);
                op_vy = op_ux;
            end
            ST_A_Z: begin
                op_ux = sdiff(az_reg, lp_z_reg);
                op_vy = op_ux;
            end
            ST_Q_XA: begin
                op_ux = sdiff(bx_reg, ax_reg);
                op_uy = sdiff(by_reg, ay_reg);
                op_vx = sdiff(cur_x_reg, ax_reg);
                op_vy = sdiff(cur_y_reg, ay_reg);
            end
            ST_Q_X3: begin
                op_ux = sdiff(cur_x_reg, prev_x_reg);
                op_uy = sdiff(cur_y_reg, prev_y_reg);
                op_vx = sdiff(ax_reg, prev_x_reg);
                op_vy = sdiff(ay_reg, prev_y_reg);
            end
            ST_Q_X4: begin
                op_ux = sdiff(cur_x_reg, prev_x_reg);
                op_uy = sdiff(cur_y_reg, prev_y_reg);
                op_vx = sdiff(bx_reg, prev_x_reg);
                op_vy = sdiff(by_reg, prev_y_reg);
            end
            default: begin
            end
        endcase
    end

    assign prod1_next = op_ux * op_vy;
    assign prod2_next = op_uy * op_vx;

    assign cross_val      = XW'(prod1_reg) - XW'(prod2_reg);
    assign cross_sign.neg = cross_val[XW-1];
    assign cross_sign.pos = !cross_val[XW-1] && (cross_val != '0);
    assign sq_val         = cross_val[SQW-1:0];
    assign sq_total       = acc_reg + sq_val;

    // ------------------------------------------------------------------------
    // Output scaling
    // ------------------------------------------------------------------------
    assign n_ext    = CCW'(n_reg);
    assign pen_full = PENW'(n_reg) * PENW'(cross_weight_reg);
    assign m_load   = (state_reg == ST_Q_OUT) && (!m_valid_reg || m_ready);

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next         = state_reg;
        oldest_next        = oldest_reg;
        count_next         = count_reg;
        lp_x_next          = lp_x_reg;
        lp_y_next          = lp_y_reg;
        lp_z_next          = lp_z_reg;
        ax_next            = ax_reg;
        ay_next            = ay_reg;
        az_next            = az_reg;
        bx_next            = bx_reg;
        by_next            = by_reg;
        rd_addr_next       = rd_addr_reg;
        pts_left_next      = pts_left_reg;
        first_next         = first_reg;
        n_next             = n_reg;
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        prev_x_next        = prev_x_reg;
        prev_y_next        = prev_y_reg;
        sa_prev_next       = sa_prev_reg;
        sa_cur_next        = sa_cur_reg;
        s3_next            = s3_reg;
        acc_next           = acc_reg;
        advance            = 1'b0;
        m_valid_next       = m_valid_reg && !m_ready;
        m_hit_count_next   = m_hit_count_reg;
        m_penalty_next     = m_penalty_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ax_next = s_pos_x;
                    ay_next = s_pos_y;
                    az_next = s_pos_z;
                    bx_next = s_target_x;
                    by_next = s_target_y;
                    if (s_func == FUNC_APPEND) begin
                        // First point after reset is always stored.
                        state_next = (count_reg == '0) ? ST_A_WR : ST_A_X;
                    end else begin
                        n_next = '0;
                        if (query_runs) begin
                            rd_addr_next  = oldest_reg;
                            pts_left_next = walk_points;
                            first_next    = 1'b1;
                            state_next    = ST_Q_LD;
                        end else begin
                            state_next = ST_Q_OUT;
                        end
                    end
                end
            end
            ST_A_X: begin
                state_next = ST_A_Y;
            end
            ST_A_Y: begin
                acc_next   = sq_val;
                state_next = ST_A_Z;
            end
            ST_A_Z: begin
                acc_next   = sq_total;
                state_next = ST_A_C;
            end
            ST_A_C: begin
                // Drop the point when it sits too close to the last one.
                if (CMPW'(sq_total) < CMPW'(min_step_sq_reg)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_A_WR;
                end
            end
            ST_A_WR: begin
                lp_x_next = ax_reg;
                lp_y_next = ay_reg;
                lp_z_next = az_reg;
                if (grown_count > (CNTW + 1)'(eff_limit)) begin
                    oldest_next = oldest_dropped;
                    count_next  = eff_limit;
                end else begin
                    count_next  = CNTW'(grown_count);
                end
                state_next = ST_IDLE;
            end
            ST_Q_LD: begin
                prev_x_next  = cur_x_reg;
                prev_y_next  = cur_y_reg;
                cur_x_next   = ram_rdata[2*COORD_WIDTH-1:COORD_WIDTH];
                cur_y_next   = ram_rdata[COORD_WIDTH-1:0];
                sa_prev_next = sa_cur_reg;
                state_next   = ST_Q_XA;
            end
            ST_Q_XA: begin
                state_next = ST_Q_X3;
            end
            ST_Q_X3: begin
                sa_cur_next = cross_sign;
                if (first_reg) begin
                    advance = 1'b1;
                end else begin
                    state_next = ST_Q_X4;
                end
            end
            ST_Q_X4: begin
                s3_next    = cross_sign;
                state_next = ST_Q_EV;
            end
            ST_Q_EV: begin
                // Proper crossing: each segment's ends on strictly opposite sides.
                if (opposite(sa_prev_reg, sa_cur_reg).pos &&
                    opposite(s3_reg, cross_sign).pos) begin
                    n_next = n_reg + CNTW'(1);
                end
                advance = 1'b1;
            end
            ST_Q_OUT: begin
                if (m_load) begin
                    m_valid_next       = 1'b1;
                    m_hit_count_next   = n_ext[HIT_COUNT_W-1:0];
                    m_penalty_next     = pen_full[PENALTY_W-1:0];
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance the walk to the next ring point, or finish.
        if (advance) begin
            first_next    = 1'b0;
            pts_left_next = pts_left_reg - CNTW'(1);
            if (pts_left_reg == CNTW'(1)) begin
                state_next = ST_Q_OUT;
            end else begin
                rd_addr_next = (rd_addr_reg == LAST_ADDR) ? '0 : rd_addr_reg + IW'(1);
                state_next   = ST_Q_LD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_valid_reg       <= 1'b0;
            oldest_reg        <= '0;
            count_reg         <= '0;
            lp_x_reg          <= '0;
            lp_y_reg          <= '0;
            lp_z_reg          <= '0;
            cross_enable_reg  <= RST_CROSS_ENABLE;
            cross_weight_reg  <= RST_CROSS_WEIGHT;
            min_step_sq_reg   <= RST_MIN_STEP_SQ;
            history_limit_reg <= RST_HISTORY_LIMIT;
            skip_recent_reg   <= RST_SKIP_RECENT;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            oldest_reg  <= oldest_next;
            count_reg   <= count_next;
            lp_x_reg    <= lp_x_next;
            lp_y_reg    <= lp_y_next;
            lp_z_reg    <= lp_z_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_CROSS_ENABLE:  cross_enable_reg  <= cfg_wdata[0];
                    CFG_CROSS_WEIGHT:  cross_weight_reg  <= cfg_wdata[WEIGHT_W-1:0];
                    CFG_MIN_STEP_SQ:   min_step_sq_reg   <= cfg_wdata[STEP_W-1:0];
                    CFG_HISTORY_LIMIT: history_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                    CFG_SKIP_RECENT:   skip_recent_reg   <= cfg_wdata[SKIP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        // Payload and datapath registers hold without reset.
        ax_reg            <= ax_next;
        ay_reg            <= ay_next;
        az_reg            <= az_next;
        bx_reg            <= bx_next;
        by_reg            <= by_next;
        rd_addr_reg       <= rd_addr_next;
        pts_left_reg      <= pts_left_next;
        first_reg         <= first_next;
        n_reg             <= n_next;
        cur_x_reg         <= cur_x_next;
        cur_y_reg         <= cur_y_next;
        prev_x_reg        <= prev_x_next;
        prev_y_reg        <= prev_y_next;
        sa_prev_reg       <= sa_prev_next;
        sa_cur_reg        <= sa_cur_next;
        s3_reg            <= s3_next;
        acc_reg           <= acc_next;
        prod1_reg         <= prod1_next;
        prod2_reg         <= prod2_next;
        m_hit_count_reg   <= m_hit_count_next;
        m_penalty_reg     <= m_penalty_next;
    end

    // Ready only between transactions; a parked result does not hold it low.
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_hit_count   = m_hit_count_reg;
    assign m_penalty     = m_penalty_reg;

endmodule

// File: rtl/phcc_checker.sv
// ----------------------------------------------------------------------------
// phcc_checker
// Port-level checks of the path history crossing counter, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module phcc_checker
    import phcc_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [HIT_COUNT_W-1:0]   m_hit_count,
    input logic [PENALTY_W-1:0]     m_penalty
);

    // Reset empties the result register.
    `PHCC_ASSERT_ALWAYS(a_reset_clears_result, aclk,
        !aresetn |=> !m_valid, "result valid after reset")

    // An accepted transaction leaves the sequencer busy in the cycle after acceptance.
    `PHCC_ASSERT(a_busy_after_accept, aclk, aresetn,
        s_valid && s_ready |=> !s_ready, "ready right after accept")

    // A result only appears out of a busy cycle.
    `PHCC_ASSERT(a_result_from_work, aclk, aresetn,
        $rose(m_valid) |-> $past(!s_ready), "result without work")

    // A stalled result holds.
    `PHCC_ASSERT(a_result_holds, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_hit_count) && $stable(m_penalty),
        "stalled result changed")

endmodule

bind path_history_crossing_counter phcc_checker u_phcc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_hit_count   (m_hit_count),
    .m_penalty     (m_penalty)
);
